>>> rtl/wma_pkg.sv
// Shared constants for the Wilder moving average unit.
package wma_pkg;

    // Width of the period register and its value after reset.
    localparam int PERIOD_W = 10;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd14;

    // The sample count stops at period + 1, so it needs one bit more than the period.
    localparam int COUNT_W = PERIOD_W + 1;

endpackage

>>> rtl/wilder_moving_average_unit.sv
// Wilder smoothing moving average over signed Q16.16 samples, using one shared divider.
// A seed-window sample is taken and the input stays ready; the sample that completes the window
// keeps the input busy while the radix-2 divider works on the seed (S_PREP, S_DIV, S_FIX).
// A recursive sample passes S_MUL, S_ADD, S_PREP, S_DIV and S_FIX before its result is offered,
// and the next sample is taken once that result (and any held seed before it) is accepted.
// Reset is synchronous, active low: period 14, sample count, seed sum and average cleared.
module wilder_moving_average_unit
    import wma_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int PERIOD_MAX   = 1023
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: period register.
    input  logic                              i_cfg_we,
    input  logic [PERIOD_W-1:0]               i_cfg_data,
    // Input stream.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,  // [SAMPLE_WIDTH-1:0] sample
    input  logic                              i_s_axis_tuser,  // [0] first
    // Output stream.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,  // [SAMPLE_WIDTH-1:0] average
    output logic                              o_m_axis_tlast   // last_of_run
);

    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SUM_W   = SAMPLE_WIDTH + PERIOD_W;
    localparam int NUM_W   = SAMPLE_WIDTH + PERIOD_W + 1;
    localparam int DCW     = $clog2(NUM_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_PREP,
        S_DIV,
        S_FIX,
        S_OUT_SEED,
        S_OUT_LAST
    } t_state;

    t_state                    r_state;
    logic [PERIOD_W-1:0]       r_period;
    logic [COUNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0]   r_sum;
    logic [SAMPLE_WIDTH-1:0]   r_prev;
    logic [SAMPLE_WIDTH-1:0]   r_sample;
    logic                      r_two;
    logic                      r_seed_op;
    logic signed [NUM_W-1:0]   r_num;
    logic                      r_neg;
    logic [NUM_W-1:0]          r_q;
    logic [PERIOD_W-1:0]       r_rem;
    logic [DCW-1:0]            r_dcnt;
    logic [SAMPLE_WIDTH-1:0]   r_out;
    logic [SAMPLE_WIDTH-1:0]   r_hold;
    logic                      r_out_last;

    logic [PERIOD_W-1:0]       p_eff;
    logic [PERIOD_W-1:0]       p_m1;
    logic [COUNT_W-1:0]        p_cnt;
    logic                      in_acc;
    logic [SAMPLE_WIDTH-1:0]   in_sample;
    logic [COUNT_W-1:0]        eff_cnt;
    logic signed [SUM_W-1:0]   eff_sum;
    logic signed [SUM_W-1:0]   n_sum;
    logic signed [NUM_W-1:0]   n_prod;
    logic [PERIOD_W+1:0]       shifted;
    logic [PERIOD_W+1:0]       trial;
    logic                      q_bit;
    logic [PERIOD_W-1:0]       n_rem;
    logic [NUM_W-1:0]          q_signed;

    // Effective period, clamped to the largest supported value.
    assign p_eff = (32'(r_period) > PERIOD_MAX) ? PERIOD_W'(PERIOD_MAX) : r_period;
    assign p_m1  = p_eff - 1'b1;
    assign p_cnt = {1'b0, p_eff};

    // Input word and the state as seen after an optional restart of the series.
    assign in_acc    = i_s_axis_tvalid && o_s_axis_tready;
    assign in_sample = i_s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign eff_cnt   = i_s_axis_tuser ? '0 : r_cnt;
    assign eff_sum   = i_s_axis_tuser ? '0 : r_sum;
    assign n_sum     = eff_sum + {{(SUM_W-SAMPLE_WIDTH){in_sample[SAMPLE_WIDTH-1]}}, in_sample};

    // Previous average times (period - 1).
    assign n_prod = $signed(r_prev) * $signed({1'b0, p_m1});

    // One restoring division step: bring down the next dividend bit and try the subtract.
    assign shifted = {1'b0, r_rem, r_q[NUM_W-1]};
    assign trial   = shifted - {2'b00, p_eff};
    assign q_bit   = !trial[PERIOD_W+1];
    assign n_rem   = q_bit ? trial[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];

    // Quotient with the sign restored; truncation toward zero comes from dividing magnitudes.
    assign q_signed = r_neg ? (~r_q + 1'b1) : r_q;

    // Sequencer, datapath registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_period <= PERIOD_RESET;
            r_cnt    <= '0;
            r_sum    <= '0;
            r_prev   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        // A restart clears the previous average; count and sum follow below.
                        if (i_s_axis_tuser) begin
                            r_prev <= '0;
                        end
                        if (p_eff == '0) begin
                            // Period zero drops the sample, but a restart still clears.
                            r_cnt <= eff_cnt;
                            r_sum <= eff_sum;
                        end else if (eff_cnt < p_cnt) begin
                            // Seed window: accumulate, and divide once the window is full.
                            r_sum <= n_sum;
                            r_cnt <= eff_cnt + 1'b1;
                            if (eff_cnt + 1'b1 == p_cnt) begin
                                r_num     <= {n_sum[SUM_W-1], n_sum};
                                r_seed_op <= 1'b1;
                                r_state   <= S_PREP;
                            end
                        end else begin
                            // Recursive phase; the first one also releases the held seed.
                            r_sample  <= in_sample;
                            r_two     <= (eff_cnt == p_cnt);
                            r_seed_op <= 1'b0;
                            if (eff_cnt == p_cnt) begin
                                r_cnt <= eff_cnt + 1'b1;
                            end
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_num   <= n_prod;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_num <= r_num
                           + {{(NUM_W-SAMPLE_WIDTH){r_sample[SAMPLE_WIDTH-1]}}, r_sample};
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_neg   <= r_num[NUM_W-1];
                    r_q     <= r_num[NUM_W-1] ? (~r_num + 1'b1) : r_num;
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_q    <= {r_q[NUM_W-2:0], q_bit};
                    r_rem  <= n_rem;
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DCW'(NUM_W - 1)) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_prev <= q_signed[SAMPLE_WIDTH-1:0];
                    if (r_seed_op) begin
                        r_state <= S_IDLE;
                    end else if (r_two) begin
                        r_out      <= r_prev;
                        r_out_last <= 1'b0;
                        r_hold     <= q_signed[SAMPLE_WIDTH-1:0];
                        r_state    <= S_OUT_SEED;
                    end else begin
                        r_out      <= q_signed[SAMPLE_WIDTH-1:0];
                        r_out_last <= 1'b1;
                        r_state    <= S_OUT_LAST;
                    end
                end
                S_OUT_SEED: begin
                    if (i_m_axis_tready) begin
                        r_out      <= r_hold;
                        r_out_last <= 1'b1;
                        r_state    <= S_OUT_LAST;
                    end
                end
                S_OUT_LAST: begin
                    if (i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Stream outputs.
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = (r_state == S_OUT_SEED) || (r_state == S_OUT_LAST);
    assign o_m_axis_tdata  = TDATA_W'(r_out);
    assign o_m_axis_tlast  = r_out_last;

endmodule

>>> rtl/wma_checker.sv
// Port-level checks for the Wilder moving average unit, bound to the top level.
module wma_checker
    import wma_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32,
    parameter int PERIOD_MAX   = 1023
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [PERIOD_W-1:0]               i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    input  logic                              o_s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,  // [SAMPLE_WIDTH-1:0] sample
    input  logic                              i_s_axis_tuser,  // [0] first
    input  logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,  // [SAMPLE_WIDTH-1:0] average
    input  logic                              o_m_axis_tlast   // last_of_run
);

    // The block never takes a new word while a result is still being offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input ready while output valid");

    // A held seed is always followed directly by the final result of the same sample.
    a_seed_then_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast)
        |=> (o_m_axis_tvalid && o_m_axis_tlast))
        else $error("seed word not followed by final word");

    // After the final word the block returns to taking input.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast)
        |=> (!o_m_axis_tvalid && o_s_axis_tready))
        else $error("output continued after final word");

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled output word changed");

    // Reset leaves no output pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind wilder_moving_average_unit wma_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .PERIOD_MAX  (PERIOD_MAX)
) u_wma_checker (.*);
